// ===== design/kcl_pkg.sv =====
//------------------------------------------------------------------------------
// kcl_pkg
// Shared constants, codes and types of the keypad code lock controller.
//------------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int MAX_DIGITS   = 8;
  localparam int LEN_W        = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W        = 17;
  localparam int MAX_CODE_LEN = 8;

  // command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_KEY    = 3'd1;
  localparam logic [2:0] CMD_REMOTE = 3'd2;
  localparam logic [2:0] CMD_BELL   = 3'd3;
  localparam logic [2:0] CMD_ECHO   = 3'd4;

  // key codes
  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  // signal codes
  localparam logic [2:0] SIG_NONE     = 3'd0;
  localparam logic [2:0] SIG_KEY      = 3'd1;
  localparam logic [2:0] SIG_UNLOCKED = 3'd2;
  localparam logic [2:0] SIG_WRONG    = 3'd3;
  localparam logic [2:0] SIG_CLEARED  = 3'd4;
  localparam logic [2:0] SIG_BELL     = 3'd5;
  localparam logic [2:0] SIG_PRESENCE = 3'd6;

  // indicator colors
  localparam logic [1:0] COLOR_OFF   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;

  // notification codes
  localparam logic [1:0] NOTIFY_NONE     = 2'd0;
  localparam logic [1:0] NOTIFY_BELL     = 2'd1;
  localparam logic [1:0] NOTIFY_PRESENCE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_CODE_DIGITS    = 3'd0;
  localparam logic [2:0] CFG_CODE_LENGTH    = 3'd1;
  localparam logic [2:0] CFG_UNLOCK_TICKS   = 3'd2;
  localparam logic [2:0] CFG_RED_TICKS      = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD_CM   = 3'd4;
  localparam logic [2:0] CFG_IDLE_TICKS     = 3'd5;
  localparam logic [2:0] CFG_BELL_LED_TICKS = 3'd6;
  localparam logic [2:0] CFG_COOLDOWN_TICKS = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  key_code;
    logic [15:0] echo_us;
  } kcl_item_t;

  typedef struct packed {
    logic [31:0] code_digits;
    logic [3:0]  code_length;
    logic [15:0] unlock_ticks;
    logic [15:0] red_ticks;
    logic [8:0]  threshold_cm;
    logic [15:0] idle_ticks;
    logic [15:0] bell_led_ticks;
    logic [15:0] cooldown_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    logic       match;
    logic [3:0] count;
  } kcl_entry_t;

  typedef struct packed {
    logic       is_unlocked;
    logic [1:0] rgb_color;
    logic       led_on;
    logic [2:0] signal;
    logic [1:0] notify;
    logic       sleep_request;
  } kcl_result_t;

endpackage

`default_nettype wire

// ===== design/kcl_entry.sv =====
//------------------------------------------------------------------------------
// kcl_entry
// Entry buffer: collects digits, tracks overflow and compares with the code.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_entry (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 fire,
  input  kcl_pkg::kcl_item_t  item,
  input  kcl_pkg::kcl_cfg_t   cfg,
  output kcl_pkg::kcl_entry_t status
);
  import kcl_pkg::*;

  logic [3:0]       digits_r [MAX_DIGITS];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             is_key, is_digit, is_clear, has_room, store;
  logic [3:0]       nib_idx [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] digit_ok;
  logic             len_ok, len_eq;

  assign is_key   = (item.command == CMD_KEY);
  assign is_digit = is_key && (item.key_code < KEY_STAR);
  assign is_clear = is_key && ((item.key_code == KEY_STAR) || (item.key_code == KEY_HASH));
  assign has_room = (len_r < LEN_W'(MAX_DIGITS));
  assign store    = fire && is_digit && has_room;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      nib_idx[i]  = cfg.code_length - 4'd1 - 4'(i);
      digit_ok[i] = (i >= int'(cfg.code_length)) ||
                    (digits_r[i] == cfg.code_digits[{nib_idx[i][2:0], 2'b00} +: 4]);
    end
  end

  assign len_ok = (cfg.code_length >= 4'd1) && (cfg.code_length <= 4'(MAX_CODE_LEN));
  assign len_eq = (5'(len_r) == 5'(cfg.code_length));

  assign status.match = !ovf_r && len_ok && len_eq && (&digit_ok);
  assign status.count = 4'(len_nxt);

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (fire) begin
      if (is_clear) begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (is_digit) begin
        if (has_room) begin
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      digits_r[len_r[IDX_W-1:0]] <= item.key_code;
    end
  end

endmodule

`default_nettype wire

// ===== design/kcl_ctrl.sv =====
//------------------------------------------------------------------------------
// kcl_ctrl
// Lock, indicator, LED, presence and saturating timer state for one item.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  kcl_pkg::kcl_item_t   item,
  input  kcl_pkg::kcl_cfg_t    cfg,
  input  wire                  match,
  output kcl_pkg::kcl_result_t res
);
  import kcl_pkg::*;

  logic             unlocked_r, unlocked_nxt;
  logic             red_r, red_nxt;
  logic [1:0]       color_r, color_nxt;
  logic             present_r, present_nxt;
  logic             led_r, led_nxt;
  logic [CNT_W-1:0] since_r, since_nxt;
  logic [CNT_W-1:0] idle_r, idle_nxt;
  logic [CNT_W-1:0] bell_r, bell_nxt;
  logic [CNT_W-1:0] notify_r, notify_nxt;
  logic [2:0]       sig;
  logic [1:0]       notif;
  logic [20:0]      echo_x17, thr_x1000;
  logic             near;
  logic [CNT_W-1:0] red_limit;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  assign echo_x17  = {1'b0, item.echo_us, 4'b0000} + 21'(item.echo_us);
  assign thr_x1000 = 21'(cfg.threshold_cm) * 21'd1000;
  assign near      = (item.echo_us != 16'd0) && (echo_x17 <= thr_x1000);
  assign red_limit = CNT_W'(cfg.unlock_ticks) + CNT_W'(cfg.red_ticks);

  always_comb begin
    unlocked_nxt = unlocked_r;
    red_nxt      = red_r;
    color_nxt    = color_r;
    present_nxt  = present_r;
    led_nxt      = led_r;
    since_nxt    = since_r;
    idle_nxt     = idle_r;
    bell_nxt     = bell_r;
    notify_nxt   = notify_r;
    sig          = SIG_NONE;
    notif        = NOTIFY_NONE;
    case (item.command)
      CMD_TICK: begin
        since_nxt  = sat_inc(since_r);
        idle_nxt   = sat_inc(idle_r);
        bell_nxt   = sat_inc(bell_r);
        notify_nxt = sat_inc(notify_r);
        if (led_r && (bell_nxt > CNT_W'(cfg.bell_led_ticks))) begin
          led_nxt = 1'b0;
        end
        if (unlocked_r && (since_nxt > CNT_W'(cfg.unlock_ticks))) begin
          unlocked_nxt = 1'b0;
          color_nxt    = COLOR_RED;
          red_nxt      = 1'b1;
          since_nxt    = '0;
        end
        if (red_nxt && (since_nxt > red_limit)) begin
          color_nxt = COLOR_OFF;
          red_nxt   = 1'b0;
        end
        if (!unlocked_nxt && (idle_nxt > CNT_W'(cfg.idle_ticks)) && present_r) begin
          idle_nxt = '0;
        end
      end
      CMD_KEY: begin
        if (item.key_code <= KEY_HASH) begin
          idle_nxt = '0;
          if (item.key_code == KEY_HASH) begin
            if (match) begin
              unlocked_nxt = 1'b1;
              since_nxt    = '0;
              color_nxt    = COLOR_GREEN;
              sig          = SIG_UNLOCKED;
            end else begin
              color_nxt = COLOR_OFF;
              sig       = SIG_WRONG;
            end
          end else if (item.key_code == KEY_STAR) begin
            color_nxt = COLOR_OFF;
            sig       = SIG_CLEARED;
          end else begin
            sig = SIG_KEY;
          end
        end
      end
      CMD_REMOTE: begin
        unlocked_nxt = 1'b1;
        since_nxt    = '0;
        color_nxt    = COLOR_GREEN;
        idle_nxt     = '0;
        sig          = SIG_UNLOCKED;
      end
      CMD_BELL: begin
        led_nxt  = 1'b1;
        bell_nxt = '0;
        sig      = SIG_BELL;
        if (notify_r > CNT_W'(cfg.cooldown_ticks)) begin
          notify_nxt = '0;
          notif      = NOTIFY_BELL;
        end
      end
      CMD_ECHO: begin
        if (near) begin
          if (!present_r) begin
            present_nxt = 1'b1;
            led_nxt     = 1'b1;
            idle_nxt    = '0;
            sig         = SIG_PRESENCE;
            if (notify_r > CNT_W'(cfg.cooldown_ticks)) begin
              notify_nxt = '0;
              notif      = NOTIFY_PRESENCE;
            end
          end
        end else if (present_r) begin
          present_nxt = 1'b0;
          led_nxt     = 1'b0;
        end
      end
      default: begin
        sig = SIG_NONE;
      end
    endcase
  end

  assign res.is_unlocked   = unlocked_nxt;
  assign res.rgb_color     = color_nxt;
  assign res.led_on        = led_nxt;
  assign res.signal        = sig;
  assign res.notify        = notif;
  assign res.sleep_request = (idle_nxt > CNT_W'(cfg.idle_ticks)) && !unlocked_nxt && !present_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlocked_r <= 1'b0;
      red_r      <= 1'b0;
      color_r    <= COLOR_OFF;
      present_r  <= 1'b0;
      led_r      <= 1'b0;
      since_r    <= '0;
      idle_r     <= '0;
      bell_r     <= '0;
      notify_r   <= '0;
    end else if (fire) begin
      unlocked_r <= unlocked_nxt;
      red_r      <= red_nxt;
      color_r    <= color_nxt;
      present_r  <= present_nxt;
      led_r      <= led_nxt;
      since_r    <= since_nxt;
      idle_r     <= idle_nxt;
      bell_r     <= bell_nxt;
      notify_r   <= notify_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/keypad_code_lock_controller_core.sv =====
//------------------------------------------------------------------------------
// keypad_code_lock_controller_core
// Keypad code lock: configuration registers, input register, item logic
// and result register.
//------------------------------------------------------------------------------
// An accepted item waits in the input register and, once the output is free,
// passes into the result register. Throughput: one item per cycle unless
// stalled, set by the single registered pass from the input register through
// the lock and entry logic into the result register.
// Reset: synchronous, active low; clears all lock state and loads the default
// configuration. Entry digits are undefined until written; no clearing pass.
`default_nettype none

module keypad_code_lock_controller_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_command,
  input  wire  [3:0]  in_key_code,
  input  wire  [15:0] in_echo_us,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_is_unlocked,
  output logic [1:0]  out_rgb_color,
  output logic        out_led_on,
  output logic [2:0]  out_signal,
  output logic [1:0]  out_notify,
  output logic        out_sleep_request,
  output logic [3:0]  out_entry_count
);
  import kcl_pkg::*;

  kcl_cfg_t    cfg_r;
  kcl_item_t   item_r;
  logic        in_valid_r;
  logic        out_valid_r;
  logic        fire, out_free, in_take;
  kcl_entry_t  entry;
  kcl_result_t res;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_digits    <= 32'h0000_1234;
      cfg_r.code_length    <= 4'd4;
      cfg_r.unlock_ticks   <= 16'd10000;
      cfg_r.red_ticks      <= 16'd3000;
      cfg_r.threshold_cm   <= 9'd200;
      cfg_r.idle_ticks     <= 16'd10000;
      cfg_r.bell_led_ticks <= 16'd2000;
      cfg_r.cooldown_ticks <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_DIGITS:    cfg_r.code_digits    <= cfg_wdata;
        CFG_CODE_LENGTH:    cfg_r.code_length    <= cfg_wdata[3:0];
        CFG_UNLOCK_TICKS:   cfg_r.unlock_ticks   <= cfg_wdata[15:0];
        CFG_RED_TICKS:      cfg_r.red_ticks      <= cfg_wdata[15:0];
        CFG_THRESHOLD_CM:   cfg_r.threshold_cm   <= cfg_wdata[8:0];
        CFG_IDLE_TICKS:     cfg_r.idle_ticks     <= cfg_wdata[15:0];
        CFG_BELL_LED_TICKS: cfg_r.bell_led_ticks <= cfg_wdata[15:0];
        CFG_COOLDOWN_TICKS: cfg_r.cooldown_ticks <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command  <= in_command;
      item_r.key_code <= in_key_code;
      item_r.echo_us  <= in_echo_us;
    end
  end

  kcl_entry u_entry (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg_r),
    .status (entry)
  );

  kcl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .match (entry.match),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      out_is_unlocked   <= res.is_unlocked;
      out_rgb_color     <= res.rgb_color;
      out_led_on        <= res.led_on;
      out_signal        <= res.signal;
      out_notify        <= res.notify;
      out_sleep_request <= res.sleep_request;
      out_entry_count   <= entry.count;
    end
  end

  assign out_valid = out_valid_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item left the input register without a result");

  a_sleep_only_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_unlocked && out_sleep_request))
    else $error("sleep requested while unlocked");

  a_notify_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_notify != NOTIFY_NONE)) |->
      ((out_signal == SIG_BELL) || (out_signal == SIG_PRESENCE)))
    else $error("notification without bell or presence event");

  a_unlock_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_signal == SIG_UNLOCKED)) |->
      (out_is_unlocked && (out_rgb_color == COLOR_GREEN)))
    else $error("unlock event without open latch and green");

endmodule

`default_nettype wire
